### rtl/core/vtam_pkg.sv
// shared types, codes and constants for the vertex table adjacency matrix unit
`default_nettype none
package vtam_pkg;

  localparam int VTAM_MAX_VERTICES = 64;
  localparam int KEY_W   = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int INDEX_W = 6;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd1;
  localparam logic [OP_W-1:0] OP_LINK   = 3'd2;
  localparam logic [OP_W-1:0] OP_UNLINK = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] ST_PRESENT = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key_a;
    logic signed [KEY_W-1:0] key_b;
  } vtam_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [INDEX_W-1:0] index;
  } vtam_rsp_t;

  // qualified update command broadcast to every cell
  typedef struct packed {
    logic             add;
    logic             link;
    logic             unlink;
    logic             remove;
    logic [KEY_W-1:0] key;
  } vtam_ctl_t;

endpackage
`default_nettype wire

### rtl/core/vertex_table_adjacency_matrix_unit.sv
// top level of the vertex table with symmetric adjacency matrix
//
//  channel | valid     | stall     | word                 | direction
//  request | req_valid | req_stall | req  (op,key_a,key_b)| in
//  result  | rsp_valid | rsp_stall | rsp  (status,index)  | out
//
// each word has an accept step and an update step: on accept the request is latched
// and every cell compares its key in parallel; the update step applies the update and
// loads the result register. a waiting result holds the update step until it is taken.
// rst is synchronous: count and matrix rows clear at once, keys stay undefined.
`default_nettype none
module vertex_table_adjacency_matrix_unit #(
  parameter int MAX_VERTICES = vtam_pkg::VTAM_MAX_VERTICES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire vtam_pkg::vtam_req_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output vtam_pkg::vtam_rsp_t      rsp
);

  localparam int N  = MAX_VERTICES;
  localparam int CW = $clog2(N+1);
  localparam int PW = $clog2(N);
  localparam int IW = (PW > vtam_pkg::INDEX_W) ? PW : vtam_pkg::INDEX_W;

  // control states
  localparam logic S_IDLE   = 1'b0;
  localparam logic S_UPDATE = 1'b1;

  logic                state;
  logic                state_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  vtam_pkg::vtam_req_t cur;
  vtam_pkg::vtam_ctl_t ctl;
  vtam_pkg::vtam_rsp_t rsp_next;

  logic                take;
  logic                fire;
  logic                full;
  logic [N-1:0]        ma_vec;
  logic [N-1:0]        mb_vec;
  logic [N-1:0]        keep;
  logic                found_a;
  logic                found_b;
  logic [PW-1:0]       pa;
  logic [PW-1:0]       pb;

  logic [vtam_pkg::KEY_W-1:0] cell_key [N];
  logic [N-1:0]               cell_row [N];

  assign take      = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  // the update waits only while the result register is still occupied
  assign fire      = (state == S_UPDATE) && (!rsp_valid || !rsp_stall);
  assign full      = (count == CW'(N));

  // ---- row of cells, each passes its key and row to the one below ----
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [vtam_pkg::KEY_W-1:0] up_key;
    logic [N-1:0]               up_row;

    if (i == N-1) begin : g_end
      assign up_key = '0;
      assign up_row = '0;
    end else begin : g_mid
      assign up_key = cell_key[i+1];
      assign up_row = cell_row[i+1];
    end

    vtam_cell #(.N(N), .IDX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .capture (take),
      .key_a   (req.key_a),
      .key_b   (req.key_b),
      .count   (count),
      .ctl     (ctl),
      .ma_vec  (ma_vec),
      .mb_vec  (mb_vec),
      .keep    (keep),
      .nxt_key (up_key),
      .nxt_row (up_row),
      .ma      (ma_vec[i]),
      .mb      (mb_vec[i]),
      .key     (cell_key[i]),
      .row     (cell_row[i])
    );
  end

  // ---- positions of the two endpoints ----
  vtam_enc #(.N(N)) u_enc_a (
    .hit   (ma_vec),
    .found (found_a),
    .pos   (pa)
  );

  vtam_enc #(.N(N)) u_enc_b (
    .hit   (mb_vec),
    .found (found_b),
    .pos   (pb)
  );

  // rows and columns from the removed position upward shift down by one
  always_comb begin
    for (int c = 0; c < N; c++) begin
      keep[c] = PW'(c) < pa;
    end
  end

  // ---- decode of the latched request ----
  always_comb begin
    ctl        = '0;
    ctl.key    = cur.key_a;
    rsp_next   = '0;
    count_next = count;
    unique case (cur.op) inside
      vtam_pkg::OP_ADD: begin
        if (found_a) begin
          rsp_next.status = vtam_pkg::ST_PRESENT;
          rsp_next.index  = vtam_pkg::INDEX_W'(IW'(pa));
        end else if (full) begin
          rsp_next.status = vtam_pkg::ST_FULL;
        end else begin
          rsp_next.index = vtam_pkg::INDEX_W'(count);
          ctl.add        = fire;
          count_next     = count + CW'(1);
        end
      end
      vtam_pkg::OP_FIND: begin
        if (found_a) begin
          rsp_next.index = vtam_pkg::INDEX_W'(IW'(pa));
        end else begin
          rsp_next.status = vtam_pkg::ST_MISSING;
        end
      end
      vtam_pkg::OP_LINK, vtam_pkg::OP_UNLINK: begin
        if (found_a && found_b) begin
          rsp_next.index = vtam_pkg::INDEX_W'(IW'(pa));
          ctl.link       = fire && (cur.op == vtam_pkg::OP_LINK);
          ctl.unlink     = fire && (cur.op == vtam_pkg::OP_UNLINK);
        end else begin
          rsp_next.status = vtam_pkg::ST_MISSING;
        end
      end
      vtam_pkg::OP_REMOVE: begin
        if (found_a) begin
          rsp_next.index = vtam_pkg::INDEX_W'(IW'(pa));
          ctl.remove     = fire;
          count_next     = count - CW'(1);
        end else begin
          rsp_next.status = vtam_pkg::ST_MISSING;
        end
      end
      default: begin
        // unused op codes complete with nothing changed
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (take) state_next = S_UPDATE;
      S_UPDATE: if (fire) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (take) begin
      cur <= req;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  // distinct keys: never more than one cell matches key_a
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    $countones(ma_vec) <= 1)
    else $error("more than one cell matched key_a");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(N))
    else $error("vertex count beyond table size");

  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("update did not load a result");

  a_accept_update: assert property (@(posedge clk) disable iff (rst)
    take |=> (state == S_UPDATE))
    else $error("accepted word not followed by update cycle");

  // a link sets both mirrored bits of the matrix
  a_link_mirror: assert property (@(posedge clk) disable iff (rst)
    ctl.link |=> (cell_row[pb][pa] && cell_row[pa][pb]))
    else $error("link did not set both mirrored bits");
`endif

endmodule
`default_nettype wire

### rtl/core/vtam_cell.sv
// one table cell: a key, its adjacency row, and the match flags for the current word
`default_nettype none
module vtam_cell #(
  parameter int N   = vtam_pkg::VTAM_MAX_VERTICES,
  parameter int IDX = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      capture,
  input  wire logic [vtam_pkg::KEY_W-1:0] key_a,
  input  wire logic [vtam_pkg::KEY_W-1:0] key_b,
  input  wire logic [$clog2(N+1)-1:0]    count,
  input  wire vtam_pkg::vtam_ctl_t       ctl,
  input  wire logic [N-1:0]              ma_vec,
  input  wire logic [N-1:0]              mb_vec,
  input  wire logic [N-1:0]              keep,
  input  wire logic [vtam_pkg::KEY_W-1:0] nxt_key,
  input  wire logic [N-1:0]              nxt_row,
  output logic                           ma,
  output logic                           mb,
  output logic [vtam_pkg::KEY_W-1:0]     key,
  output logic [N-1:0]                   row
);

  localparam int CW = $clog2(N+1);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic         live;
  logic [N-1:0] edge_set;
  logic [N-1:0] src_row;
  logic [N-1:0] row_next;

  assign live = IDX_C < count;

  // column compaction: bits below the removed position stay, the rest move down
  assign src_row  = keep[IDX] ? row : nxt_row;
  assign edge_set = (ma ? mb_vec : '0) | (mb ? ma_vec : '0);

  always_comb begin
    row_next = row;
    if (ctl.remove) begin
      row_next = (src_row & keep) | ((src_row >> 1) & ~keep);
    end else if (ctl.link) begin
      row_next = row | edge_set;
    end else if (ctl.unlink) begin
      row_next = row & ~edge_set;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ma  <= 1'b0;
      mb  <= 1'b0;
      row <= '0;
    end else begin
      if (capture) begin
        ma <= live && (key == key_a);
        mb <= live && (key == key_b);
      end
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.remove && !keep[IDX]) begin
      key <= nxt_key;
    end else if (ctl.add && (IDX_C == count)) begin
      key <= ctl.key;
    end
  end

endmodule
`default_nettype wire

### rtl/core/vtam_enc.sv
// match vector to position: keys are distinct so at most one flag is set
`default_nettype none
module vtam_enc #(
  parameter int N = vtam_pkg::VTAM_MAX_VERTICES
) (
  input  wire logic [N-1:0]         hit,
  output logic                      found,
  output logic [$clog2(N)-1:0]      pos
);

  localparam int PW = $clog2(N);

  always_comb begin
    pos = '0;
    for (int i = 0; i < N; i++) begin
      pos = pos | (hit[i] ? PW'(i) : '0);
    end
  end

  assign found = |hit;

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for the vertex table adjacency matrix unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV           = vtam_pkg::VTAM_MAX_VERTICES;
  localparam int IDLE_PCT     = 38;
  localparam int POOL_SIZE    = 96;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  // op codes the block must ignore
  localparam logic [vtam_pkg::OP_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [vtam_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [vtam_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

  // a request word together with the result it must produce
  typedef struct packed {
    vtam_pkg::vtam_req_t req;
    vtam_pkg::vtam_rsp_t rsp;
  } pending_word_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  vtam_pkg::vtam_req_t req       = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  vtam_pkg::vtam_rsp_t rsp;

  // shadow of the vertex table: key list, fill level and edge bits
  logic [vtam_pkg::KEY_W-1:0] vt_keys [NV];
  int                         vt_count;
  logic [NV-1:0]              vt_adj  [NV];

  pending_word_t              pending_q [$];
  pending_word_t              head_word;
  logic [vtam_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  bit burst_mode = 1'b0;
  int error_count = 0;
  int cycle_count = 0;
  int peak_count = 0;
  int op_tally [8];
  int status_tally [4];

  vertex_table_adjacency_matrix_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_q.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // shadow table: position lookup, removal with compaction, and the predictor
  // ---------------------------------------------------------------------------

  // list position of a key, -1 when it is not held
  function automatic int slot_of(logic [vtam_pkg::KEY_W-1:0] key);
    for (int i = 0; i < vt_count; i++)
      if (vt_keys[i] == key) return i;
    return -1;
  endfunction

  // close the gap at position p in the list, the rows and the columns
  function automatic void drop_slot(int p);
    int n = vt_count;
    for (int r = p; r + 1 < n; r++) begin
      vt_keys[r] = vt_keys[r+1];
      vt_adj[r]  = vt_adj[r+1];
    end
    vt_adj[n-1] = '0;
    for (int r = 0; r + 1 < n; r++) begin
      for (int c = p; c + 1 < n; c++) vt_adj[r][c] = vt_adj[r][c+1];
      vt_adj[r][n-1] = 1'b0;
    end
    vt_count = n - 1;
  endfunction

  // apply one request word to the shadow table and return its result word
  function automatic vtam_pkg::vtam_rsp_t predict_vertex_op(vtam_pkg::vtam_req_t w);
    vtam_pkg::vtam_rsp_t r;
    int pa;
    int pb;
    r.status = vtam_pkg::ST_DONE;
    r.index  = '0;
    case (w.op) inside
      vtam_pkg::OP_ADD: begin
        pa = slot_of(w.key_a);
        if (pa >= 0) begin
          // duplicate: report where it already sits
          r.status = vtam_pkg::ST_PRESENT;
          r.index  = pa[vtam_pkg::INDEX_W-1:0];
        end else if (vt_count >= NV) begin
          r.status = vtam_pkg::ST_FULL;
        end else begin
          r.index = vt_count[vtam_pkg::INDEX_W-1:0];
          vt_keys[vt_count] = w.key_a;
          vt_count++;
        end
      end
      vtam_pkg::OP_FIND: begin
        pa = slot_of(w.key_a);
        if (pa >= 0) r.index = pa[vtam_pkg::INDEX_W-1:0];
        else r.status = vtam_pkg::ST_MISSING;
      end
      vtam_pkg::OP_LINK, vtam_pkg::OP_UNLINK: begin
        pa = slot_of(w.key_a);
        pb = slot_of(w.key_b);
        if (pa >= 0 && pb >= 0) begin
          // symmetric update, a self link touches only the diagonal
          vt_adj[pa][pb] = (w.op == vtam_pkg::OP_LINK);
          vt_adj[pb][pa] = (w.op == vtam_pkg::OP_LINK);
          r.index = pa[vtam_pkg::INDEX_W-1:0];
        end else begin
          r.status = vtam_pkg::ST_MISSING;
        end
      end
      vtam_pkg::OP_REMOVE: begin
        pa = slot_of(w.key_a);
        if (pa >= 0) begin
          drop_slot(pa);
          r.index = pa[vtam_pkg::INDEX_W-1:0];
        end else begin
          r.status = vtam_pkg::ST_MISSING;
        end
      end
      default: ;  // spare op codes leave the table alone
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  function automatic vtam_pkg::vtam_req_t mk_word(logic [vtam_pkg::OP_W-1:0] op,
                                                  logic [vtam_pkg::KEY_W-1:0] a,
                                                  logic [vtam_pkg::KEY_W-1:0] b);
    vtam_pkg::vtam_req_t w;
    w.op    = op;
    w.key_a = a;
    w.key_b = b;
    return w;
  endfunction

  // mostly keys already held, some from a shared pool, a few fresh ones
  function automatic logic [vtam_pkg::KEY_W-1:0] pick_key();
    int r = $urandom_range(99);
    if (vt_count > 0 && r < 60) return vt_keys[$urandom_range(vt_count - 1)];
    if (r < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // well-formed traffic: weights for add and remove steer the fill level
  function automatic vtam_pkg::vtam_req_t make_graph_word(int add_w, int rem_w);
    vtam_pkg::vtam_req_t w;
    int r;
    int rest;
    r = $urandom_range(add_w + rem_w + 54);
    w.key_a = pick_key();
    w.key_b = $urandom;
    if (r < add_w) begin
      w.op = vtam_pkg::OP_ADD;
    end else if (r < add_w + rem_w) begin
      w.op = vtam_pkg::OP_REMOVE;
    end else begin
      rest = r - add_w - rem_w;
      if (rest < 15) begin
        w.op = vtam_pkg::OP_FIND;
      end else if (rest < 52) begin
        w.op    = (rest < 40) ? vtam_pkg::OP_LINK : vtam_pkg::OP_UNLINK;
        w.key_b = ($urandom_range(99) < 10) ? w.key_a : pick_key();
      end else begin
        w.op = OP_SPARE5 + 3'($urandom_range(2));
      end
    end
    return w;
  endfunction

  // offer one word, hold it until taken, then record what it must produce
  task automatic send_word(vtam_pkg::vtam_req_t w);
    pending_word_t e;
    while (!burst_mode && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    e.req = w;
    e.rsp = predict_vertex_op(w);
    pending_q = {pending_q, e};
    op_tally[w.op]++;
    status_tally[e.rsp.status]++;
    if (vt_count > peak_count) peak_count = vt_count;
  endtask

  // stop offering words until every result has been taken
  task automatic pause_until_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall and the comparison against the oldest entry
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("mismatch, cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: status %0d index %0d",
                                  rsp.status, rsp.index));
      end else begin
        head_word = pending_q.pop_front();
        if (rsp.status !== head_word.rsp.status)
          report_mismatch($sformatf("op %0d key_a %h key_b %h: status %0d, expected %0d",
                                    head_word.req.op, head_word.req.key_a,
                                    head_word.req.key_b, rsp.status, head_word.rsp.status));
        if (rsp.index !== head_word.rsp.index)
          report_mismatch($sformatf("op %0d key_a %h key_b %h: index %0d, expected %0d",
                                    head_word.req.op, head_word.req.key_a,
                                    head_word.req.key_b, rsp.index, head_word.rsp.index));
      end
    end
    rsp_stall <= burst_mode ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // corner keys, every op, misses, duplicates, self link, spare ops, shifts
  task automatic test_directed();
    send_word(mk_word(vtam_pkg::OP_FIND,   32'd5, 32'd0));          // empty table misses
    send_word(mk_word(vtam_pkg::OP_REMOVE, 32'd5, 32'd0));
    send_word(mk_word(vtam_pkg::OP_LINK,   32'd5, 32'd6));
    send_word(mk_word(vtam_pkg::OP_ADD,    32'h8000_0000, 32'hffff_ffff));
    send_word(mk_word(vtam_pkg::OP_ADD,    32'h7fff_ffff, 32'd0));
    send_word(mk_word(vtam_pkg::OP_ADD,    32'd0, 32'h8000_0000));
    send_word(mk_word(vtam_pkg::OP_ADD,    32'hffff_ffff, 32'h7fff_ffff));
    send_word(mk_word(vtam_pkg::OP_ADD,    32'h8000_0000, 32'd0));   // duplicate
    send_word(mk_word(vtam_pkg::OP_FIND,   32'hffff_ffff, 32'd0));
    send_word(mk_word(vtam_pkg::OP_LINK,   32'h8000_0000, 32'h7fff_ffff));
    send_word(mk_word(vtam_pkg::OP_LINK,   32'd0, 32'hffff_ffff));
    send_word(mk_word(vtam_pkg::OP_LINK,   32'd0, 32'd0));           // self link
    // second end missing
    send_word(mk_word(vtam_pkg::OP_LINK,   32'h7fff_ffff, 32'h0001_2345));
    send_word(mk_word(vtam_pkg::OP_UNLINK, 32'h8000_0000, 32'h7fff_ffff));
    send_word(mk_word(vtam_pkg::OP_UNLINK, 32'h0001_2345, 32'd0));   // first end missing
    send_word(mk_word(vtam_pkg::OP_LINK,   32'h8000_0000, 32'hffff_ffff));
    // middle, later ones shift
    send_word(mk_word(vtam_pkg::OP_REMOVE, 32'h7fff_ffff, 32'd0));
    send_word(mk_word(vtam_pkg::OP_FIND,   32'd0, 32'd0));
    send_word(mk_word(vtam_pkg::OP_FIND,   32'h7fff_ffff, 32'd0));
    send_word(mk_word(OP_SPARE5, 32'hffff_ffff, 32'hffff_ffff));
    send_word(mk_word(OP_SPARE6, 32'd0, 32'hffff_ffff));
    send_word(mk_word(OP_SPARE7, 32'h8000_0000, 32'h7fff_ffff));
    send_word(mk_word(vtam_pkg::OP_REMOVE, 32'hffff_ffff, 32'd0));   // last
    send_word(mk_word(vtam_pkg::OP_REMOVE, 32'h8000_0000, 32'd0));   // first
    send_word(mk_word(vtam_pkg::OP_REMOVE, 32'd0, 32'd0));           // back to empty
  endtask

  // fill every slot, overflow, touch the top position, then empty again
  task automatic test_fill_and_overflow();
    logic [vtam_pkg::KEY_W-1:0] k;
    while (vt_count > 0)
      send_word(mk_word(vtam_pkg::OP_REMOVE, vt_keys[$urandom_range(vt_count - 1)],
                        $urandom));
    while (vt_count < NV) begin
      k = $urandom;
      if (slot_of(k) < 0) send_word(mk_word(vtam_pkg::OP_ADD, k, $urandom));
    end
    do k = $urandom; while (slot_of(k) >= 0);
    send_word(mk_word(vtam_pkg::OP_ADD, k, $urandom));                // table full
    send_word(mk_word(vtam_pkg::OP_ADD, vt_keys[NV-1], $urandom));    // duplicate beats full
    send_word(mk_word(vtam_pkg::OP_FIND, vt_keys[NV-1], $urandom));
    send_word(mk_word(vtam_pkg::OP_LINK, vt_keys[0], vt_keys[NV-1]));
    send_word(mk_word(vtam_pkg::OP_LINK, vt_keys[NV-1], vt_keys[NV-1]));
    repeat (16)
      send_word(mk_word(vtam_pkg::OP_LINK, vt_keys[$urandom_range(NV - 1)],
                        vt_keys[$urandom_range(NV - 1)]));
    send_word(mk_word(vtam_pkg::OP_REMOVE, vt_keys[NV-1], $urandom));
    send_word(mk_word(vtam_pkg::OP_ADD, k, $urandom));                // refills the top slot
    send_word(mk_word(vtam_pkg::OP_REMOVE, vt_keys[0], $urandom));
    send_word(mk_word(vtam_pkg::OP_REMOVE, vt_keys[NV/2], $urandom));
    while (vt_count > 0)
      send_word(mk_word(vtam_pkg::OP_REMOVE, vt_keys[$urandom_range(vt_count - 1)],
                        $urandom));
  endtask

  // grow, churn and shrink phases of well-formed traffic
  task automatic test_random_churn();
    repeat (300) send_word(make_graph_word(50, 5));
    repeat (300) send_word(make_graph_word(20, 20));
    repeat (300) send_word(make_graph_word(5, 45));
  endtask

  // back-to-back words with the result side never stalling
  task automatic test_burst();
    burst_mode = 1'b1;
    repeat (200) send_word(make_graph_word(25, 20));
    burst_mode = 1'b0;
  endtask

  // each word waits for the table to go quiet first
  task automatic test_drain_pause();
    repeat (20) begin
      pause_until_drained();
      send_word(make_graph_word(30, 30));
    end
  endtask

  // any op code with keys that are mostly unknown
  task automatic test_noise();
    vtam_pkg::vtam_req_t w;
    repeat (80) begin
      w.op    = 3'($urandom_range(7));
      w.key_a = ($urandom_range(1) != 0) ? pick_key() : $urandom;
      w.key_b = ($urandom_range(1) != 0) ? pick_key() : $urandom;
      send_word(w);
    end
  endtask

  initial begin
    vt_count = 0;
    for (int i = 0; i < NV; i++) vt_adj[i] = '0;
    // pool with the sign and range corners plus random keys
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_and_overflow();
    test_random_churn();
    test_burst();
    test_drain_pause();
    test_noise();

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_q.size()));

    $display("covered %0d request words: %0d add, %0d find, %0d link, %0d unlink, %0d remove",
             op_tally.sum(), op_tally[vtam_pkg::OP_ADD], op_tally[vtam_pkg::OP_FIND],
             op_tally[vtam_pkg::OP_LINK], op_tally[vtam_pkg::OP_UNLINK],
             op_tally[vtam_pkg::OP_REMOVE]);
    $display("outcomes %0d done, %0d not found, %0d duplicate, %0d full; peak fill %0d of %0d",
             status_tally[vtam_pkg::ST_DONE], status_tally[vtam_pkg::ST_MISSING],
             status_tally[vtam_pkg::ST_PRESENT], status_tally[vtam_pkg::ST_FULL],
             peak_count, NV);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
